@@ rtl/aplt_pkg.sv @@
// aplt_pkg: shared types and constants for the animation playhead loop timer
// no dependencies
`timescale 1ns / 1ps

package aplt_pkg;

    localparam int EVENT_SLOTS = 8;
    localparam int SLOT_W      = 3;
    localparam int TIME_W      = 32;
    localparam int DUR_W       = 31;
    localparam int SPEED_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CNT_W       = 6;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SET_TIME  = 3'd1,
        OP_PLAY      = 3'd2,
        OP_STOP      = 3'd3,
        OP_SET_EVENT = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CFG_LOOP_MODE = 3'd0,
        CFG_BEGIN     = 3'd1,
        CFG_END       = 3'd2,
        CFG_DURATION  = 3'd3,
        CFG_SPEED     = 3'd4,
        CFG_REVERSE   = 3'd5,
        CFG_SUB_CTRL  = 3'd6
    } cfg_idx_t;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_LOOP,
        ST_EVENTS,
        ST_DONE
    } state_t;

    // handshake between sequencer and the serial divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

@@ rtl/aplt_mul.sv @@
// aplt_mul: shift-add multiplier, one multiplier bit per cycle
// depends on aplt_pkg
`timescale 1ns / 1ps

module aplt_mul
    import aplt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [TIME_W-1:0]   a,
    input  logic signed [SPEED_W-1:0]  b,
    output logic                       done,
    output logic signed [TIME_W+SPEED_W-1:0] product
);

    localparam int PW = TIME_W + SPEED_W;

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] mcand_reg, mcand_next;
    logic [SPEED_W-1:0] mplier_reg, mplier_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = PW'(a);
            mplier_next = b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // top bit of a two's complement multiplier has negative weight
            if (mplier_reg[0])
            begin
                if (cnt_reg == CNT_W'(SPEED_W - 1))
                    acc_next = acc_reg - mcand_reg;
                else
                    acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SPEED_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/aplt_div.sv @@
// aplt_div: restoring divider, one quotient bit per cycle
// depends on aplt_pkg
`timescale 1ns / 1ps

module aplt_div
    import aplt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [DUR_W-1:0]  divisor,
    output div_ctl_t          ctl,
    output logic              q_lsb,
    output logic [DUR_W-1:0]  remainder
);

    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [DUR_W:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DUR_W+1:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[TIME_W-1]} - {2'b00, divisor};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DUR_W+1])
            begin
                rem_next = trial[DUR_W:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DUR_W-1:0], quo_reg[TIME_W-1]};
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign ctl.start  = start;
    assign ctl.busy   = busy_reg;
    assign ctl.done   = done_reg;
    assign q_lsb      = quo_reg[0];
    assign remainder  = rem_reg[DUR_W-1:0];

endmodule

@@ rtl/animation_playhead_loop_timer.sv @@
// animation_playhead_loop_timer: top level, sequencer and state registers
// depends on aplt_pkg, aplt_mul, aplt_div
`timescale 1ns / 1ps
//
// one item in, one item out. in_valid/in_stall carry an operation with its
// value, slot and enable; out_valid/out_stall return the playhead time, the
// in-loop time, play flags and the fired event mask.
// a tick that advances runs a bit-serial multiply (dt times speed) and, in
// repeat or ping-pong mode with a nonzero duration, a restoring divide by the
// loop duration, then scans the event slots, one per cycle. set time takes the
// divide, not the multiply or scan; play, stop and slot writes skip all three.
// the next item is accepted once the result register is free, so one item
// is in work at a time; a stalled result holds its value and blocks input.
// reset stops play, zeroes both times, disarms all slots and loads the
// register defaults. event times are not reset: a slot is only compared
// after an arming write has stored its time.
// configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce this.
module animation_playhead_loop_timer
    import aplt_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [TIME_W-1:0]           cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  operation,
    input  logic signed [TIME_W-1:0]    value,
    input  logic [SLOT_W-1:0]           event_slot,
    input  logic                        event_enable,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [TIME_W-1:0]    current_time,
    output logic signed [TIME_W-1:0]    loop_time,
    output logic                        is_playing,
    output logic                        stopped_now,
    output logic [EVENT_SLOTS-1:0]      event_mask,
    output logic                        evaluated
);

    localparam int PW = TIME_W + SPEED_W;

    logic [1:0] mode_reg;
    logic signed [TIME_W-1:0] begin_reg, end_reg;
    logic [DUR_W-1:0] dur_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic reverse_reg, subctl_reg;

    logic signed [TIME_W-1:0] play_reg, play_next;
    logic signed [TIME_W-1:0] inloop_reg, inloop_next;
    logic signed [TIME_W-1:0] old_reg, old_next;
    logic playing_reg, playing_next;
    logic [EVENT_SLOTS-1:0] armed_reg, armed_next;
    logic signed [TIME_W-1:0] ev_time_reg [EVENT_SLOTS];

    state_t state_reg, state_next;
    op_t op_reg;
    logic is_tick_reg, is_tick_next;
    logic stop_reg, stop_next;
    logic eval_reg, eval_next;
    logic [EVENT_SLOTS-1:0] fired_reg, fired_next;
    logic [SLOT_W-1:0] scan_reg, scan_next;
    logic neg_reg, neg_next;
    logic outv_reg, outv_next;

    logic accept;
    logic mul_start, mul_done, div_start;
    logic signed [PW-1:0] product;
    div_ctl_t div_ctl;
    logic q_lsb;
    logic [DUR_W-1:0] rem;

    logic signed [PW:0] step_p;
    logic signed [PW:0] step_q;
    logic signed [PW:0] sum;
    logic [TIME_W-1:0] mag;
    logic signed [TIME_W-1:0] lo, hi, et;
    logic signed [TIME_W-1:0] dr;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || outv_reg;

    // the multiplier loads its operand at the accepting edge
    aplt_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (value),
        .b       (speed_reg),
        .done    (mul_done),
        .product (product)
    );

    aplt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag),
        .divisor   (dur_reg),
        .ctl       (div_ctl),
        .q_lsb     (q_lsb),
        .remainder (rem)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NONE;
            begin_reg   <= '0;
            end_reg     <= TIME_W'(65536);
            dur_reg     <= DUR_W'(65536);
            speed_reg   <= SPEED_W'(256);
            reverse_reg <= 1'b0;
            subctl_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOOP_MODE: mode_reg    <= cfg_data[1:0];
                CFG_BEGIN:     begin_reg   <= cfg_data;
                CFG_END:       end_reg     <= cfg_data;
                CFG_DURATION:  dur_reg     <= cfg_data[DUR_W-1:0];
                CFG_SPEED:     speed_reg   <= cfg_data[SPEED_W-1:0];
                CFG_REVERSE:   reverse_reg <= cfg_data[0];
                CFG_SUB_CTRL:  subctl_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    case (operation)
                        OP_TICK:     state_next = ST_MUL;
                        OP_SET_TIME: state_next = ST_ADD;
                        default:     state_next = ST_DONE;
                    endcase
                end
            ST_MUL:
                if (!playing_reg || subctl_reg)
                    state_next = ST_DONE;
                else if (mul_done)
                    state_next = ST_ADD;
            ST_ADD:
                state_next = (mode_reg == MODE_NONE || dur_reg == '0) ? ST_LOOP : ST_DIV;
            ST_DIV:
                if (div_ctl.done)
                    state_next = ST_LOOP;
            ST_LOOP:
                state_next = is_tick_reg ? ST_EVENTS : ST_DONE;
            ST_EVENTS:
                if (scan_reg == SLOT_W'(EVENT_SLOTS - 1))
                    state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign mul_start = (state_reg == ST_IDLE) && accept && (operation == OP_TICK);
    assign div_start = (state_reg == ST_ADD) && (state_next == ST_DIV);
    // magnitude taken from the sign of the final time, valid in the start cycle
    assign mag = play_reg[TIME_W-1] ? (TIME_W'(0) - play_reg) : play_reg;

    // datapath
    always_comb
    begin
        play_next    = play_reg;
        inloop_next  = inloop_reg;
        old_next     = old_reg;
        playing_next = playing_reg;
        armed_next   = armed_reg;
        is_tick_next = is_tick_reg;
        stop_next    = stop_reg;
        eval_next    = eval_reg;
        fired_next   = fired_reg;
        scan_next    = scan_reg;
        neg_next     = neg_reg;
        outv_next    = outv_reg;
        step_p       = reverse_reg ? -(PW+1)'(product) : (PW+1)'(product);
        step_q       = (step_p + (PW+1)'(128)) >>> 8;
        sum          = (PW+1)'(play_reg) + step_q;
        lo           = (old_reg < inloop_reg) ? old_reg : inloop_reg;
        hi           = (old_reg < inloop_reg) ? inloop_reg : old_reg;
        et           = ev_time_reg[scan_reg];
        dr           = TIME_W'(dur_reg) - TIME_W'(rem);

        if (out_valid && !out_stall)
            outv_next = 1'b0;

        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    stop_next    = 1'b0;
                    eval_next    = 1'b0;
                    fired_next   = '0;
                    scan_next    = '0;
                    is_tick_next = (operation == OP_TICK);
                    old_next     = inloop_reg;
                    case (operation)
                        OP_SET_TIME: play_next = value;
                        OP_PLAY:
                            if (!playing_reg)
                            begin
                                playing_next = 1'b1;
                                eval_next    = 1'b1;
                            end
                        OP_STOP:
                            if (playing_reg)
                            begin
                                playing_next = 1'b0;
                                stop_next    = 1'b1;
                                eval_next    = 1'b1;
                            end
                        OP_SET_EVENT:
                            if (event_slot < SLOT_W'(EVENT_SLOTS - 1) + SLOT_W'(1)
                                || EVENT_SLOTS == (1 << SLOT_W))
                                armed_next[event_slot] = event_enable;
                        default: ;
                    endcase
                end
            ST_MUL:
                if (mul_done)
                begin
                    if (sum > (PW+1)'(32'sh7fffffff))
                        play_next = 32'sh7fffffff;
                    else if (sum < -(PW+1)'(64'sh80000000))
                        play_next = 32'sh80000000;
                    else
                        play_next = sum[TIME_W-1:0];
                end
            ST_ADD:
            begin
                eval_next = 1'b1;
                neg_next  = (play_reg <= 0);
                if (mode_reg == MODE_NONE)
                begin
                    if (play_reg > end_reg || play_reg < begin_reg)
                    begin
                        play_next    = (play_reg > end_reg) ? end_reg : begin_reg;
                        playing_next = 1'b0;
                        stop_next    = playing_reg;
                    end
                end
            end
            ST_LOOP:
                if (mode_reg == MODE_NONE)
                    inloop_next = play_reg;
                else if (dur_reg == '0)
                    inloop_next = '0;
                else if (mode_reg == MODE_REPEAT)
                    inloop_next = neg_reg ? dr : TIME_W'(rem);
                else
                    inloop_next = q_lsb ? dr : TIME_W'(rem);
            ST_EVENTS:
            begin
                if (armed_reg[scan_reg] && et > lo && et <= hi)
                    fired_next[scan_reg] = 1'b1;
                scan_next = scan_reg + SLOT_W'(1);
            end
            ST_DONE:
                outv_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            play_reg    <= '0;
            inloop_reg  <= '0;
            playing_reg <= 1'b0;
            armed_reg   <= '0;
            outv_reg    <= 1'b0;
            scan_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            play_reg    <= play_next;
            inloop_reg  <= inloop_next;
            playing_reg <= playing_next;
            armed_reg   <= armed_next;
            outv_reg    <= outv_next;
            scan_reg    <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_reg     <= old_next;
        is_tick_reg <= is_tick_next;
        stop_reg    <= stop_next;
        eval_reg    <= eval_next;
        fired_reg   <= fired_next;
        neg_reg     <= neg_next;
        if (accept)
        begin
            op_reg  <= op_t'(operation);
            if (op_t'(operation) == OP_SET_EVENT && event_enable)
                ev_time_reg[event_slot] <= value;
        end
    end

    assign out_valid    = outv_reg;
    assign current_time = play_reg;
    assign loop_time    = inloop_reg;
    assign is_playing   = playing_reg;
    assign stopped_now  = stop_reg;
    assign event_mask   = fired_reg;
    assign evaluated    = eval_reg;

    // a set-time item must always report an evaluation
    a_settime_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && op_reg == OP_SET_TIME) |-> eval_next)
        else $error("set time without evaluation");

    // events only fire on ticks
    a_mask_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_tick_reg) |-> (event_mask == '0))
        else $error("event mask on non-tick item");

    // no new item while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken with result pending");

    // stop flag implies not playing
    a_stop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stopped_now) |-> !is_playing)
        else $error("stopped but playing");

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for animation_playhead_loop_timer
// depends on aplt_pkg and the rtl top level; predicts each result item in-line
`timescale 1ns / 1ps

module tb;
    import aplt_pkg::*;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] val;
        logic [2:0]  slot;
        logic        en;
    } cmd_t;

    typedef struct {
        logic [31:0] ctime;
        logic [31:0] ltime;
        logic        playing;
        logic        stopped;
        logic [7:0]  mask;
        logic        evald;
    } status_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [2:0] operation;
    logic signed [TIME_W-1:0] value;
    logic [SLOT_W-1:0] event_slot;
    logic event_enable;
    logic out_valid;
    logic out_stall;
    logic signed [TIME_W-1:0] current_time;
    logic signed [TIME_W-1:0] loop_time;
    logic is_playing;
    logic stopped_now;
    logic [EVENT_SLOTS-1:0] event_mask;
    logic evaluated;

    animation_playhead_loop_timer dut (.*);

    // predictor copy of registers and state
    logic [1:0]  m_mode;
    logic signed [31:0] m_begin, m_end;
    logic [30:0] m_dur;
    logic signed [15:0] m_speed;
    logic m_rev, m_sub;
    logic signed [31:0] m_time, m_loop;
    logic m_playing;
    logic signed [31:0] m_ev_time [EVENT_SLOTS];
    logic [EVENT_SLOTS-1:0] m_armed;

    cmd_t    pending_cmds[$];
    status_t expected_status[$];
    int      send_idle_pct, recv_idle_pct;
    int      mismatches, n_results, n_fired, cycles;
    bit      stim_done;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 600000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // loop rule on m_time; returns 1 when play was stopped by it
    function automatic bit run_loop_rule();
        logic signed [63:0] t, d, mag, q, r, res;
        bit clamp, was;
        t = m_time;
        d = {33'd0, m_dur};
        clamp = 0;
        if (m_mode == MODE_NONE)
        begin
            if (m_time > m_end)
            begin
                m_time = m_end;
                clamp = 1;
            end
            else if (m_time < m_begin)
            begin
                m_time = m_begin;
                clamp = 1;
            end
            m_loop = m_time;
            if (clamp)
            begin
                was = m_playing;
                m_playing = 0;
                return was;
            end
            return 0;
        end
        if (d == 0)
        begin
            m_loop = 0;
            return 0;
        end
        mag = t > 0 ? t : -t;
        q = mag / d;
        r = mag % d;
        if (m_mode == MODE_REPEAT)
            res = t > 0 ? r : d - r;
        else
            res = q[0] == 0 ? r : d - r;
        m_loop = res[31:0];
        return 0;
    endfunction

    function automatic status_t predict_status(cmd_t c);
        status_t s;
        logic signed [63:0] p, sum;
        logic signed [31:0] old, lo, hi;
        s.stopped = 0;
        s.evald = 0;
        s.mask = 0;
        case (c.op)
            OP_TICK:
            begin
                if (m_playing && !m_sub)
                begin
                    p = $signed(c.val) * m_speed;
                    if (m_rev)
                        p = -p;
                    p = p + 128;
                    p = p >>> 8;
                    old = m_loop;
                    sum = m_time + p;
                    if (sum > 64'sh7fffffff)
                        m_time = 32'h7fffffff;
                    else if (sum < -64'sh80000000)
                        m_time = 32'h80000000;
                    else
                        m_time = sum[31:0];
                    s.stopped = run_loop_rule();
                    s.evald = 1;
                    lo = old < m_loop ? old : m_loop;
                    hi = old < m_loop ? m_loop : old;
                    for (int i = 0; i < EVENT_SLOTS; i++)
                        if (m_armed[i] && m_ev_time[i] > lo && m_ev_time[i] <= hi)
                            s.mask[i] = 1;
                end
            end
            OP_SET_TIME:
            begin
                m_time = c.val;
                s.stopped = run_loop_rule();
                s.evald = 1;
            end
            OP_PLAY:
            begin
                if (!m_playing)
                begin
                    m_playing = 1;
                    s.evald = 1;
                end
            end
            OP_STOP:
            begin
                if (m_playing)
                begin
                    m_playing = 0;
                    s.stopped = 1;
                    s.evald = 1;
                end
            end
            OP_SET_EVENT:
            begin
                if (c.en)
                begin
                    m_ev_time[c.slot] = c.val;
                    m_armed[c.slot] = 1;
                end
                else
                    m_armed[c.slot] = 0;
            end
            default: ;
        endcase
        s.ctime = m_time;
        s.ltime = m_loop;
        s.playing = m_playing;
        return s;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
        end
        else
        begin
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    expected_status.push_back(predict_status(c));
                    operation <= c.op;
                    value <= c.val;
                    event_slot <= c.slot;
                    event_enable <= c.en;
                    in_valid <= 1;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                status_t e;
                n_results++;
                if (expected_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item at cycle %0d", cycles);
                end
                else
                begin
                    e = expected_status.pop_front();
                    if (event_mask != 0)
                        n_fired++;
                    if (current_time !== e.ctime || loop_time !== e.ltime
                        || is_playing !== e.playing || stopped_now !== e.stopped
                        || event_mask !== e.mask || evaluated !== e.evald)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: exp t=%h l=%h p=%b s=%b m=%h e=%b",
                                     n_results, e.ctime, e.ltime, e.playing, e.stopped,
                                     e.mask, e.evald,
                                     " got t=%h l=%h p=%b s=%b m=%h e=%b",
                                     current_time, loop_time, is_playing, stopped_now,
                                     event_mask, evaluated);
                    end
                end
            end
            out_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_LOOP_MODE: m_mode = data[1:0];
            CFG_BEGIN:     m_begin = data;
            CFG_END:       m_end = data;
            CFG_DURATION:  m_dur = data[30:0];
            CFG_SPEED:     m_speed = data[15:0];
            CFG_REVERSE:   m_rev = data[0];
            CFG_SUB_CTRL:  m_sub = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic add_cmd(logic [2:0] op, logic [31:0] val, logic [2:0] slot = 3'd0,
                           logic en = 1'b0);
        cmd_t c;
        c.op = op;
        c.val = val;
        c.slot = slot;
        c.en = en;
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_status.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h3ffff);
            2: return -$urandom_range(0, 32'h3ffff);
            default: return $urandom_range(0, 32'h1ffff) - 32'h10000;
        endcase
    endfunction

    // a phase of mostly play/tick sequences with armed events and some noise
    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            int k;
            k = $urandom_range(99);
            if (k < 55)
                add_cmd(OP_TICK, $urandom_range(9) == 0 ? $urandom
                                 : $urandom_range(0, 32'h8000) - 32'h2000);
            else if (k < 65)
                add_cmd(OP_SET_TIME, rand_time());
            else if (k < 75)
                add_cmd(OP_PLAY, $urandom);
            else if (k < 80)
                add_cmd(OP_STOP, $urandom);
            else if (k < 95)
                add_cmd(OP_SET_EVENT, rand_time(), 3'($urandom_range(7)),
                        $urandom_range(3) != 0);
            else
                add_cmd(3'($urandom_range(5, 7)), $urandom, 3'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_setting();
        write_reg(CFG_LOOP_MODE, $urandom_range(3));
        write_reg(CFG_BEGIN, -$urandom_range(0, 32'h30000));
        write_reg(CFG_END, $urandom_range(0, 32'h30000));
        write_reg(CFG_DURATION, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h30000));
        write_reg(CFG_SPEED, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1024) - 256);
        write_reg(CFG_REVERSE, $urandom_range(1));
        write_reg(CFG_SUB_CTRL, $urandom_range(5) == 0);
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        operation = 0;
        value = 0;
        event_slot = 0;
        event_enable = 0;
        out_stall = 0;
        stim_done = 0;
        mismatches = 0;
        n_results = 0;
        n_fired = 0;
        send_idle_pct = 21;
        recv_idle_pct = 85;
        m_mode = 0;
        m_begin = 0;
        m_end = 65536;
        m_dur = 65536;
        m_speed = 256;
        m_rev = 0;
        m_sub = 0;
        m_time = 0;
        m_loop = 0;
        m_playing = 0;
        m_armed = 0;
        for (int i = 0; i < EVENT_SLOTS; i++)
            m_ev_time[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // directed: defaults, no-loop clamp, overrun while stopped gives no stop flag
        add_cmd(OP_TICK, 32'h10000);
        add_cmd(OP_STOP, 0);
        add_cmd(OP_SET_TIME, 32'h7fffffff);
        add_cmd(OP_PLAY, 0);
        add_cmd(OP_PLAY, 0);
        add_cmd(OP_SET_EVENT, 32'h8000, 3'd7, 1'b1);
        add_cmd(OP_SET_EVENT, 32'h10000, 3'd0, 1'b1);
        add_cmd(OP_SET_TIME, 0);
        add_cmd(OP_TICK, 32'h8000);
        add_cmd(OP_TICK, 32'h7fffffff);
        add_cmd(OP_PLAY, 0);
        add_cmd(OP_SET_TIME, 32'h80000000);
        add_cmd(OP_SET_EVENT, 0, 3'd0, 1'b0);
        add_cmd(3'd5, 32'hffffffff, 3'd7, 1'b1);
        add_cmd(3'd7, 0);
        drain();
        // repeat, extreme speed, saturation and t=0 giving the full duration
        write_reg(CFG_LOOP_MODE, 1);
        write_reg(CFG_SPEED, 16'h7fff);
        write_reg(CFG_DURATION, 31'h7fffffff);
        add_cmd(OP_SET_TIME, 0);
        add_cmd(OP_PLAY, 0);
        add_cmd(OP_TICK, 32'h7fffffff);
        add_cmd(OP_TICK, 32'h7fffffff);
        drain();
        write_reg(CFG_REVERSE, 1);
        write_reg(CFG_SPEED, 16'h8000);
        write_reg(CFG_LOOP_MODE, 2);
        write_reg(CFG_DURATION, 0);
        add_cmd(OP_TICK, 32'h80000000);
        add_cmd(OP_TICK, 32'hffffffff);
        drain();
        write_reg(CFG_DURATION, 1);
        write_reg(CFG_LOOP_MODE, 3);
        write_reg(CFG_SUB_CTRL, 1);
        add_cmd(OP_TICK, 32'h12345);
        add_cmd(OP_SET_TIME, 32'hfffe0001);
        drain();
        // inverted bounds
        write_reg(CFG_SUB_CTRL, 0);
        write_reg(CFG_LOOP_MODE, 0);
        write_reg(CFG_BEGIN, 32'h7fffffff);
        write_reg(CFG_END, 32'h80000000);
        add_cmd(OP_PLAY, 0);
        add_cmd(OP_SET_TIME, 5);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 21;
            end
            if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_setting();
            add_cmd(OP_PLAY, 0);
            random_phase(68);
            drain();
        end
        stim_done = 1;

        $display("covered %0d result items over 14 register settings, %0d with events",
                 n_results, n_fired);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ animation_playhead_loop_timer.f @@
rtl/aplt_pkg.sv
rtl/aplt_mul.sv
rtl/aplt_div.sv
rtl/animation_playhead_loop_timer.sv
tb/tb.sv
